### sv/pse_pkg.sv
package pse_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int ACTION_W = 3;
   localparam int NUMBER_W = 31;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int DEPTH_W  = 7;

   localparam int DIV_STEPS = DATA_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH   = 3'd0,
      ACT_ADD    = 3'd1,
      ACT_SUB    = 3'd2,
      ACT_MUL    = 3'd3,
      ACT_DIV    = 3'd4,
      ACT_FINISH = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_UNDER   = 3'd1,
      ST_DIVZERO = 3'd2,
      ST_OVER    = 3'd3,
      ST_HALTED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_UNDER   = 2'd1,
      ERR_DIVZERO = 2'd2,
      ERR_OVER    = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      UPD_NONE,
      UPD_PUSH,
      UPD_POP,
      UPD_COMBINE,
      UPD_CLEAR
   } upd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_MUL,
      S_DIV
   } state_type;

   typedef struct packed {
      logic       take;
      logic       commit;
      upd_type    upd;
      logic       err_set;
      err_type    err_code;
      logic       err_clr;
      status_type status;
      logic       fin;
      logic       mul_load;
      logic       div_start;
      logic       div_step;
   } cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      err_type             err;
      logic                cnt_zero;
      logic                cnt_one;
      logic                full;
      logic                top_zero;
      logic                out_free;
      logic                div_done;
   } sts_type;

   function automatic status_type err_status(err_type e);
      status_type s;
      unique case (e)
         ERR_UNDER:   s = ST_UNDER;
         ERR_DIVZERO: s = ST_DIVZERO;
         ERR_OVER:    s = ST_OVER;
         ERR_NONE:    s = ST_OK;
         default:     s = ST_OK;
      endcase
      return s;
   endfunction

endpackage

### sv/pse_ctrl.sv
module pse_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pse_pkg::sts_type  sts,
   output pse_pkg::cmd_type  cmd
);

   pse_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pse_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != pse_pkg::S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.upd       = pse_pkg::UPD_NONE;
      cmd.err_code  = pse_pkg::ERR_NONE;
      cmd.status    = pse_pkg::ST_OK;

      unique case (state_ff)
         pse_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = pse_pkg::S_DECIDE;
            end
         end

         pse_pkg::S_DECIDE: begin
            // hold everything until the output register can take the word
            if (sts.out_free) begin
               state_in = pse_pkg::S_IDLE;
               if (sts.action == pse_pkg::ACT_FINISH) begin
                  cmd.commit  = 1'b1;
                  cmd.upd     = pse_pkg::UPD_CLEAR;
                  cmd.err_clr = 1'b1;
                  cmd.fin     = 1'b1;
                  if (sts.err != pse_pkg::ERR_NONE) begin
                     cmd.status = pse_pkg::err_status(sts.err);
                  end else if (sts.cnt_zero) begin
                     cmd.status = pse_pkg::ST_UNDER;
                  end else begin
                     cmd.status = pse_pkg::ST_OK;
                  end
               end else if (sts.err != pse_pkg::ERR_NONE) begin
                  cmd.commit = 1'b1;
                  cmd.status = pse_pkg::ST_HALTED;
               end else begin
                  unique case (sts.action)
                     pse_pkg::ACT_PUSH: begin
                        cmd.commit = 1'b1;
                        if (sts.full) begin
                           cmd.err_set  = 1'b1;
                           cmd.err_code = pse_pkg::ERR_OVER;
                           cmd.status   = pse_pkg::ST_OVER;
                        end else begin
                           cmd.upd = pse_pkg::UPD_PUSH;
                        end
                     end
                     pse_pkg::ACT_ADD, pse_pkg::ACT_SUB,
                     pse_pkg::ACT_MUL, pse_pkg::ACT_DIV: begin
                        if (sts.cnt_zero) begin
                           cmd.commit   = 1'b1;
                           cmd.err_set  = 1'b1;
                           cmd.err_code = pse_pkg::ERR_UNDER;
                           cmd.status   = pse_pkg::ST_UNDER;
                        end else if (sts.action == pse_pkg::ACT_DIV && sts.top_zero) begin
                           // divisor stays popped
                           cmd.commit   = 1'b1;
                           cmd.upd      = pse_pkg::UPD_POP;
                           cmd.err_set  = 1'b1;
                           cmd.err_code = pse_pkg::ERR_DIVZERO;
                           cmd.status   = pse_pkg::ST_DIVZERO;
                        end else if (sts.cnt_one) begin
                           cmd.commit   = 1'b1;
                           cmd.upd      = pse_pkg::UPD_CLEAR;
                           cmd.err_set  = 1'b1;
                           cmd.err_code = pse_pkg::ERR_UNDER;
                           cmd.status   = pse_pkg::ST_UNDER;
                        end else if (sts.action == pse_pkg::ACT_MUL) begin
                           cmd.mul_load = 1'b1;
                           state_in     = pse_pkg::S_MUL;
                        end else if (sts.action == pse_pkg::ACT_DIV) begin
                           cmd.div_start = 1'b1;
                           state_in      = pse_pkg::S_DIV;
                        end else begin
                           cmd.commit = 1'b1;
                           cmd.upd    = pse_pkg::UPD_COMBINE;
                        end
                     end
                     default: begin
                        cmd.commit = 1'b1;
                     end
                  endcase
               end
            end
         end

         pse_pkg::S_MUL: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               cmd.upd    = pse_pkg::UPD_COMBINE;
               state_in   = pse_pkg::S_IDLE;
            end
         end

         pse_pkg::S_DIV: begin
            if (!sts.div_done) begin
               cmd.div_step = 1'b1;
            end else if (sts.out_free) begin
               cmd.commit = 1'b1;
               cmd.upd    = pse_pkg::UPD_COMBINE;
               state_in   = pse_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = pse_pkg::S_IDLE;
         end
      endcase
   end

endmodule

### sv/pse_datapath.sv
module pse_datapath #(
   parameter int DEPTH = pse_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [pse_pkg::ACTION_W-1:0]        req_action,
   input  logic [pse_pkg::NUMBER_W-1:0]        req_number,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pse_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [pse_pkg::DATA_W-1:0]   rsp_value,
   output logic [pse_pkg::DEPTH_W-1:0]         rsp_depth,
   output logic                                rsp_done_res,
   input  pse_pkg::cmd_type                    cmd,
   output pse_pkg::sts_type                    sts
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DW     = pse_pkg::DATA_W;

   // stack storage and registered read of the entry below the top
   logic [DW-1:0]     stack_ff [DEPTH];
   logic [DW-1:0]     rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] wr_addr;
   logic [DW-1:0]     wr_data;
   logic [CNT_W-1:0]  below;
   logic [ADDR_W-1:0] below_addr;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DW-1:0]     top_ff, top_in;
   pse_pkg::err_type  err_ff, err_in;

   logic [pse_pkg::ACTION_W-1:0] action_ff;
   logic [pse_pkg::NUMBER_W-1:0] number_ff;

   logic [DW-1:0] lhs, rhs, alu_res;
   logic [DW-1:0] mul_ff;

   logic [DW-1:0]                 quo_ff, rem_ff, dvs_ff;
   logic                          neg_ff;
   logic [pse_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [DW:0]                   rem_sh;
   logic                          rem_ge;
   logic [DW-1:0]                 div_res;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pse_pkg::STATUS_W-1:0]  status_ff;
   logic [DW-1:0]                 value_ff, value_in;
   logic [pse_pkg::DEPTH_W-1:0]   depth_ff, depth_in;
   logic                          done_ff;
   logic [CNT_W+pse_pkg::DEPTH_W-1:0] cnt_wide;

   assign below      = count_ff - CNT_W'(2);
   assign below_addr = below[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_ff[below_addr];
   end

   assign lhs = rd_data_ff;
   assign rhs = top_ff;

   // radix-2 restoring divide on magnitudes, sign fixed afterwards
   assign rem_sh  = {rem_ff, quo_ff[DW-1]};
   assign rem_ge  = (rem_sh >= {1'b0, dvs_ff});
   assign div_res = neg_ff ? (DW'(0) - quo_ff) : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= pse_pkg::DIV_CNT_W'(pse_pkg::DIV_STEPS);
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff - pse_pkg::DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff <= lhs[DW-1] ? (DW'(0) - lhs) : lhs;
         dvs_ff <= rhs[DW-1] ? (DW'(0) - rhs) : rhs;
         rem_ff <= '0;
         neg_ff <= lhs[DW-1] ^ rhs[DW-1];
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[DW-2:0], rem_ge};
         rem_ff <= rem_ge ? DW'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DW-1:0];
      end
      if (cmd.mul_load) begin
         mul_ff <= lhs * rhs;
      end
      if (cmd.take) begin
         action_ff <= req_action;
         number_ff <= req_number;
      end
   end

   always_comb begin
      unique case (action_ff)
         pse_pkg::ACT_ADD: alu_res = lhs + rhs;
         pse_pkg::ACT_SUB: alu_res = lhs - rhs;
         pse_pkg::ACT_MUL: alu_res = mul_ff;
         default:          alu_res = div_res;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      mem_we   = 1'b0;
      wr_addr  = below_addr;
      wr_data  = alu_res;
      if (cmd.commit) begin
         unique case (cmd.upd)
            pse_pkg::UPD_PUSH: begin
               mem_we   = 1'b1;
               wr_addr  = count_ff[ADDR_W-1:0];
               wr_data  = {1'b0, number_ff};
               top_in   = {1'b0, number_ff};
               count_in = count_ff + CNT_W'(1);
            end
            pse_pkg::UPD_POP: begin
               top_in   = rd_data_ff;
               count_in = count_ff - CNT_W'(1);
            end
            pse_pkg::UPD_COMBINE: begin
               mem_we   = 1'b1;
               top_in   = alu_res;
               count_in = count_ff - CNT_W'(1);
            end
            pse_pkg::UPD_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      err_in = err_ff;
      if (cmd.commit && cmd.err_clr) begin
         err_in = pse_pkg::ERR_NONE;
      end else if (cmd.commit && cmd.err_set) begin
         err_in = cmd.err_code;
      end
   end

   assign cnt_wide = (CNT_W + pse_pkg::DEPTH_W)'(count_in);

   always_comb begin
      if (cmd.fin) begin
         value_in = (cmd.status == pse_pkg::ST_OK) ? top_ff : '0;
         depth_in = '0;
      end else begin
         value_in = (count_in == '0) ? '0 : top_in;
         depth_in = cnt_wide[pse_pkg::DEPTH_W-1:0];
      end
   end

   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         err_ff       <= pse_pkg::ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (cmd.commit) begin
         status_ff <= cmd.status;
         value_ff  <= value_in;
         depth_ff  <= depth_in;
         done_ff   <= cmd.fin;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_value    = $signed(value_ff);
   assign rsp_depth    = depth_ff;
   assign rsp_done_res = done_ff;

   assign sts.action   = action_ff;
   assign sts.err      = err_ff;
   assign sts.cnt_zero = (count_ff == '0);
   assign sts.cnt_one  = (count_ff == CNT_W'(1));
   assign sts.full     = (count_ff == CNT_W'(DEPTH));
   assign sts.top_zero = (top_ff == '0);
   assign sts.out_free = ~rsp_valid_ff | ~rsp_stall;
   assign sts.div_done = (div_cnt_ff == '0);

endmodule

### sv/postfix_stack_evaluator_top.sv
// Postfix (RPN) evaluator on a DEPTH-entry stack of 32-bit signed words. Each
// request word pushes a number, combines the top two entries (add, subtract,
// multiply, divide truncating toward zero) or finishes the expression; each
// gives exactly one response word with status, top of stack, depth and a
// finish flag. One word is worked on at a time. Push, add, subtract, finish,
// error and halted words are accepted in the idle state and committed from
// the decide state. Multiply loads a registered 32x32 product in the decide
// state and commits from a multiply state. Divide goes through a decide state,
// the 32 iterations of the radix-2 divider, and a commit step. The stack sits
// in a RAM with registered read that holds the entry below the cached top
// whenever a word is decided. The response sits in an output register, so the
// next request is taken while an earlier response waits on rsp_stall; a word
// waits at its decide step and at its commit step while that register is
// still full. Stack entries need no clearing after reset.
module postfix_stack_evaluator_top #(
   parameter int DEPTH = pse_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [pse_pkg::ACTION_W-1:0]       req_action,
   input  logic [pse_pkg::NUMBER_W-1:0]       req_number,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [pse_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [pse_pkg::DATA_W-1:0]  rsp_value,
   output logic [pse_pkg::DEPTH_W-1:0]        rsp_depth,
   output logic                               rsp_done_res
);

   pse_pkg::cmd_type cmd;
   pse_pkg::sts_type sts;

   pse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pse_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_action   (req_action),
      .req_number   (req_number),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_value    (rsp_value),
      .rsp_depth    (rsp_depth),
      .rsp_done_res (rsp_done_res),
      .cmd          (cmd),
      .sts          (sts)
   );

endmodule
